// ===== hw/rtl/dqlm_pkg.sv =====
// shared types, constants and codes for the dns query latency matcher
package dqlm_pkg;

   localparam int TABLE_SETS_DEFAULT = 256;
   localparam int TABLE_WAYS_DEFAULT = 4;
   localparam int PLRU_W = 7;

   localparam logic [15:0] SVC_PORT_RESET = 16'd53;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0]  IP_VERSION_4 = 4'd4;
   localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
   localparam logic [15:0] FRAG_MASK = 16'h3fff;
   localparam logic [3:0]  MIN_IHL = 4'd5;
   localparam logic [15:0] MIN_FRAME = 16'd34;
   // ethernet header plus udp and dns headers
   localparam logic [16:0] HDR_FIXED = 17'd34;
   localparam logic [31:0] HASH_MUL_A = 32'h9E3779B1;
   localparam logic [31:0] HASH_MUL_B = 32'h85EBCA6B;

   typedef struct packed {
      logic [15:0] ether_type;
      logic [7:0]  ip_version_ihl;
      logic [7:0]  ip_protocol;
      logic [15:0] frag_field;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] udp_sport;
      logic [15:0] udp_dport;
      logic [15:0] query_id;
      logic [15:0] msg_flags;
      logic [63:0] now_ns;
      logic [15:0] frame_length;
   } req_type;

   typedef struct packed {
      logic        logged;
      logic        resp_flag;
      logic [3:0]  rcode;
      logic        matched;
      logic [63:0] delta_ns;
   } rsp_type;

   typedef struct packed {
      logic        ok;
      logic        resp;
      logic [3:0]  rcode;
      logic [31:0] client_addr;
      logic [31:0] server_addr;
      logic [31:0] port_pair;
      logic [15:0] transaction;
      logic [63:0] now_ns;
   } work_type;

   typedef struct packed {
      logic [31:0] client_addr;
      logic [31:0] server_addr;
      logic [31:0] port_pair;
      logic [15:0] transaction;
      logic [63:0] start_time;
   } entry_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_HASH,
      FS_MOD,
      FS_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_READ,
      BS_CMP,
      BS_EXEC
   } back_state_type;

endpackage

// ===== hw/rtl/dqlm_front.sv =====
// front end: header checks, flow key and set index hash
module dqlm_front import dqlm_pkg::*; #(
   parameter int TABLE_SETS = TABLE_SETS_DEFAULT,
   localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      svc_port,
   input  logic             accept_enable,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output work_type         push_work,
   output logic [SET_W-1:0] push_set
);

   localparam logic [SET_W:0] SETS_C = (SET_W+1)'(TABLE_SETS);
   localparam logic [32:0] SETS_RECIP = 33'((64'd1 << 32) / TABLE_SETS);
   localparam logic [4:0] HASH_LAST = 5'd3;
   localparam logic [4:0] MOD_LAST = 5'd1;

   front_state_type state_ff, state_in;
   work_type work_ff, work_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] q_ff, q_in;
   logic [SET_W:0] r_ff, r_in;
   logic [4:0] cnt_ff, cnt_in;

   logic [3:0] ihl;
   logic [16:0] need_len;
   logic pass, resp;
   logic [31:0] mix, prod, operand;
   logic [64:0] recip_prod;
   logic [31:0] rem_full;
   logic [SET_W:0] rem;

   assign push_work = work_ff;
   assign push_set = r_ff[SET_W-1:0];

   always_comb begin
      ihl = req_data.ip_version_ihl[3:0];
      need_len = HDR_FIXED + {11'd0, ihl, 2'b00};
      resp = req_data.msg_flags[15];
      pass = (req_data.frame_length >= MIN_FRAME) &&
             (req_data.ether_type == ETHERTYPE_IPV4) &&
             (req_data.ip_version_ihl[7:4] == IP_VERSION_4) &&
             (req_data.ip_protocol == IP_PROTO_UDP) &&
             ((req_data.frag_field & FRAG_MASK) == 16'd0) &&
             (ihl >= MIN_IHL) &&
             ({1'b0, req_data.frame_length} >= need_len) &&
             ((req_data.udp_sport == svc_port) || (req_data.udp_dport == svc_port));

      mix = (cnt_ff == HASH_LAST) ? (h_ff ^ (h_ff >> 16)) : h_ff;
      prod = mix * ((cnt_ff == HASH_LAST) ? HASH_MUL_B : HASH_MUL_A);
      unique case (cnt_ff[1:0])
         2'd0: operand = work_ff.server_addr;
         2'd1: operand = work_ff.port_pair;
         2'd2: operand = {16'd0, work_ff.transaction};
         default: operand = 32'd0;
      endcase
      // quotient estimate is at most one short, so one subtract corrects it
      recip_prod = {33'd0, h_ff} * {32'd0, SETS_RECIP};
      rem_full = h_ff - q_ff * 32'(SETS_C);
      if (rem_full >= 32'(SETS_C)) begin
         rem_full = rem_full - 32'(SETS_C);
      end
      rem = rem_full[SET_W:0];

      state_in = state_ff;
      work_in = work_ff;
      h_in = h_ff;
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      req_ready = 1'b0;
      push_valid = 1'b0;

      unique case (state_ff)
         FS_IDLE: begin
            req_ready = accept_enable;
            if (req_valid && accept_enable) begin
               work_in.ok = pass;
               work_in.resp = resp;
               work_in.rcode = resp ? req_data.msg_flags[3:0] : 4'd0;
               work_in.transaction = req_data.query_id;
               work_in.now_ns = req_data.now_ns;
               if (resp) begin
                  work_in.client_addr = req_data.dst_addr;
                  work_in.server_addr = req_data.src_addr;
                  work_in.port_pair = {req_data.udp_dport, req_data.udp_sport};
               end else begin
                  work_in.client_addr = req_data.src_addr;
                  work_in.server_addr = req_data.dst_addr;
                  work_in.port_pair = {req_data.udp_sport, req_data.udp_dport};
               end
               h_in = work_in.client_addr;
               r_in = '0;
               cnt_in = '0;
               state_in = pass ? FS_HASH : FS_PUSH;
            end
         end
         FS_HASH: begin
            if (cnt_ff == HASH_LAST) begin
               h_in = prod ^ (prod >> 13);
               cnt_in = '0;
               state_in = FS_MOD;
            end else begin
               h_in = prod ^ operand;
               cnt_in = cnt_ff + 5'd1;
            end
         end
         FS_MOD: begin
            // reciprocal multiply, then remainder with one correction
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MOD_LAST) begin
               r_in = rem;
               state_in = FS_PUSH;
            end else begin
               q_in = recip_prod[63:32];
            end
         end
         FS_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      work_ff <= work_in;
      h_ff <= h_in;
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
   end

endmodule

// ===== hw/rtl/dqlm_fifo.sv =====
// two-entry queue between front end and table engine
module dqlm_fifo import dqlm_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/dqlm_back.sv =====
// table engine: set lookup, insert, release and pseudo-lru upkeep
module dqlm_back import dqlm_pkg::*; #(
   parameter int TABLE_SETS = TABLE_SETS_DEFAULT,
   parameter int TABLE_WAYS = TABLE_WAYS_DEFAULT,
   localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1,
   localparam int WAY_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   output logic             clearing,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  work_type         pop_work,
   input  logic [SET_W-1:0] pop_set,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   localparam int LEVELS = $clog2(TABLE_WAYS);
   localparam int SPAN = 1 << LEVELS;
   localparam logic [SET_W-1:0] SET_LAST = SET_W'(TABLE_SETS - 1);

   typedef entry_type [TABLE_WAYS-1:0] row_type;

   function automatic logic [WAY_W-1:0] plru_victim(input logic [PLRU_W-1:0] bits);
      int node, lo, size, half;
      logic dir;
      node = 0;
      lo = 0;
      size = SPAN;
      for (int l = 0; l < LEVELS; l++) begin
         half = size >> 1;
         dir = bits[node];
         if (dir && (lo + half >= TABLE_WAYS)) begin
            dir = 1'b0;
         end
         if (dir) begin
            lo = lo + half;
         end
         node = 2 * node + 1 + int'(dir);
         size = half;
      end
      return lo[WAY_W-1:0];
   endfunction

   function automatic logic [PLRU_W-1:0] plru_touch(input logic [PLRU_W-1:0] bits,
                                                    input logic [WAY_W-1:0] way);
      logic [PLRU_W-1:0] b;
      int node, lo, size, half;
      logic right;
      b = bits;
      node = 0;
      lo = 0;
      size = SPAN;
      for (int l = 0; l < LEVELS; l++) begin
         half = size >> 1;
         right = (int'(way) >= lo + half);
         if (node < PLRU_W) begin
            b[node] = ~right;
         end
         if (right) begin
            lo = lo + half;
         end
         node = 2 * node + 1 + int'(right);
         size = half;
      end
      return b;
   endfunction

   row_type data_mem [TABLE_SETS];
   logic [TABLE_WAYS-1:0] valid_mem [TABLE_SETS];
   logic [PLRU_W-1:0] plru_mem [TABLE_SETS];

   back_state_type state_ff, state_in;
   work_type cur_ff, cur_in;
   logic [SET_W-1:0] set_ff, set_in, clr_ff, clr_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic hit_ff, hit_in;
   logic [WAY_W-1:0] way_ff, way_in;
   row_type row_rd_ff;
   logic [TABLE_WAYS-1:0] valid_rd_ff;
   logic [PLRU_W-1:0] plru_rd_ff;

   logic rd_en, row_we, meta_we;
   logic [SET_W-1:0] meta_addr;
   row_type row_wd;
   logic [TABLE_WAYS-1:0] valid_wd;
   logic [PLRU_W-1:0] plru_wd;
   logic [TABLE_WAYS-1:0] match;
   logic found_free;
   logic [WAY_W-1:0] match_way, free_way;
   entry_type new_entry;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign clearing = (state_ff == BS_CLEAR);
   assign meta_addr = clearing ? clr_ff : set_ff;

   always_comb begin
      for (int w = 0; w < TABLE_WAYS; w++) begin
         match[w] = valid_rd_ff[w] &&
                    (row_rd_ff[w].client_addr == cur_ff.client_addr) &&
                    (row_rd_ff[w].server_addr == cur_ff.server_addr) &&
                    (row_rd_ff[w].port_pair == cur_ff.port_pair) &&
                    (row_rd_ff[w].transaction == cur_ff.transaction);
      end
      match_way = '0;
      free_way = '0;
      found_free = 1'b0;
      for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            match_way = WAY_W'(w);
         end
         if (!valid_rd_ff[w]) begin
            free_way = WAY_W'(w);
            found_free = 1'b1;
         end
      end

      new_entry.client_addr = cur_ff.client_addr;
      new_entry.server_addr = cur_ff.server_addr;
      new_entry.port_pair = cur_ff.port_pair;
      new_entry.transaction = cur_ff.transaction;
      new_entry.start_time = cur_ff.now_ns;

      state_in = state_ff;
      cur_in = cur_ff;
      set_in = set_ff;
      clr_in = clr_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hit_in = hit_ff;
      way_in = way_ff;
      pop_ready = 1'b0;
      rd_en = 1'b0;
      row_we = 1'b0;
      meta_we = 1'b0;
      row_wd = row_rd_ff;
      valid_wd = valid_rd_ff;
      plru_wd = plru_rd_ff;

      unique case (state_ff)
         BS_CLEAR: begin
            meta_we = 1'b1;
            valid_wd = '0;
            plru_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_LAST) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (pop_valid && !rsp_valid_ff) begin
               pop_ready = 1'b1;
               cur_in = pop_work;
               set_in = pop_set;
               if (pop_work.ok) begin
                  state_in = BS_READ;
               end else begin
                  rsp_in = '0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         BS_READ: begin
            rd_en = 1'b1;
            state_in = BS_CMP;
         end
         BS_CMP: begin
            hit_in = |match;
            if (|match) begin
               way_in = match_way;
            end else if (found_free) begin
               way_in = free_way;
            end else begin
               way_in = plru_victim(plru_rd_ff);
            end
            state_in = BS_EXEC;
         end
         BS_EXEC: begin
            rsp_in.logged = 1'b1;
            rsp_in.resp_flag = cur_ff.resp;
            rsp_in.rcode = cur_ff.rcode;
            rsp_in.matched = 1'b0;
            rsp_in.delta_ns = '0;
            if (cur_ff.resp) begin
               if (hit_ff) begin
                  rsp_in.matched = 1'b1;
                  rsp_in.delta_ns = cur_ff.now_ns - row_rd_ff[way_ff].start_time;
                  meta_we = 1'b1;
                  valid_wd[way_ff] = 1'b0;
               end
            end else begin
               row_we = 1'b1;
               row_wd[way_ff] = new_entry;
               meta_we = 1'b1;
               valid_wd[way_ff] = 1'b1;
               plru_wd = plru_touch(plru_rd_ff, way_ff);
            end
            rsp_valid_in = 1'b1;
            state_in = BS_IDLE;
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         data_mem[set_ff] <= row_wd;
      end
      if (meta_we) begin
         valid_mem[meta_addr] <= valid_wd;
         plru_mem[meta_addr] <= plru_wd;
      end
      if (rd_en) begin
         row_rd_ff <= data_mem[set_ff];
         valid_rd_ff <= valid_mem[set_ff];
         plru_rd_ff <= plru_mem[set_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      set_ff <= set_in;
      rsp_ff <= rsp_in;
      hit_ff <= hit_in;
      way_ff <= way_in;
   end

endmodule

// ===== hw/rtl/dns_query_latency_matcher_core.sv =====
// top level of the dns query latency matcher
// Takes one packet header summary per request and returns one result per request, in
// order. A request that fails the IPv4/UDP/DNS checks yields an all-zero result. A query
// stores its timestamp under (client, server, ports, transaction id) in a set-associative
// table with tree pseudo-lru replacement; a response looks that key up, reports the
// wrapping time difference and frees the entry. The front end takes a request, runs the
// set hash on one shared 32x32 multiplier and reduces it modulo TABLE_SETS by a
// reciprocal multiply and one correcting subtract, then pushes it; a rejected request
// skips hash and reduction. It takes no new request until the last one is pushed; this
// front end sets the rate. The table engine behind a two-entry queue steps through
// take, read, compare and update for a passing request and answers a rejected one at
// take, and takes the next request only once its output register is empty. After reset
// the engine clears the per-set valid and replacement memory one set at a time, during
// which no request is accepted; the csr port can be written at any time. A result waits
// in an output register while the front end already takes the next request.
module dns_query_latency_matcher_core import dqlm_pkg::*; #(
   parameter int TABLE_SETS = TABLE_SETS_DEFAULT,
   parameter int TABLE_WAYS = TABLE_WAYS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
   localparam int Q_W = $bits(work_type) + SET_W;

   // dns port register
   logic [15:0] svc_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         svc_port_ff <= SVC_PORT_RESET;
      end else if (csr_write_enable) begin
         svc_port_ff <= csr_write_data;
      end
   end

   // front end to queue
   logic front_valid, front_ready;
   work_type front_work;
   logic [SET_W-1:0] front_set;

   // queue to table engine
   logic back_valid, back_ready;
   logic [Q_W-1:0] back_data;
   work_type back_work;
   logic [SET_W-1:0] back_set;
   logic clearing;

   assign back_work = back_data[Q_W-1:SET_W];
   assign back_set = back_data[SET_W-1:0];

   // hold off requests while the table is being cleared
   dqlm_front #(
      .TABLE_SETS(TABLE_SETS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .svc_port(svc_port_ff),
      .accept_enable(!clearing),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_work(front_work),
      .push_set(front_set)
   );

   dqlm_fifo #(
      .WIDTH(Q_W)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_data({front_work, front_set}),
      .pop_valid(back_valid),
      .pop_ready(back_ready),
      .pop_data(back_data)
   );

   dqlm_back #(
      .TABLE_SETS(TABLE_SETS),
      .TABLE_WAYS(TABLE_WAYS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .clearing(clearing),
      .pop_valid(back_valid),
      .pop_ready(back_ready),
      .pop_work(back_work),
      .pop_set(back_set),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   // a match only ever comes from a logged response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.matched |-> rsp_data.logged && rsp_data.resp_flag)
      else $error("match reported on a non-response");

   // rejected request carries nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.logged |->
         !rsp_data.resp_flag && rsp_data.rcode == 4'd0 && !rsp_data.matched &&
         rsp_data.delta_ns == 64'd0)
      else $error("rejected request with nonzero result");

   // no request is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("request accepted while table clears");

   // queries carry no rcode and no latency
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.logged && !rsp_data.resp_flag |->
         rsp_data.rcode == 4'd0 && rsp_data.delta_ns == 64'd0)
      else $error("query result with response fields");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the dns query latency matcher core
module tb_top import dqlm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETS = TABLE_SETS_DEFAULT;
   localparam int WAYS = TABLE_WAYS_DEFAULT;
   localparam int NUM_ENTRIES = SETS * WAYS;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   always #1 clock = ~clock;

   dns_query_latency_matcher_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // predictor state: a shadow of the flow table
   logic [31:0] tbl_client [NUM_ENTRIES];
   logic [31:0] tbl_server [NUM_ENTRIES];
   logic [31:0] tbl_ports  [NUM_ENTRIES];
   logic [15:0] tbl_tid    [NUM_ENTRIES];
   logic [63:0] tbl_start  [NUM_ENTRIES];
   logic        tbl_valid  [NUM_ENTRIES];
   logic [7:0]  tbl_plru   [SETS];
   logic [15:0] cur_svc_port;

   rsp_type expected_results[$];
   int mismatch_count = 0;
   int results_seen = 0;
   int rsp_gap = 0;
   bit rsp_idle_enable = 1'b1;

   // recent queries, so responses can be built that hit the table
   req_type recent_queries[$];

   function automatic int tree_width();
      int p = 1;
      while (p < WAYS) p = p << 1;
      return p;
   endfunction

   function automatic int flow_set(logic [31:0] ca, logic [31:0] sa, logic [31:0] pp,
                                   logic [31:0] tid);
      logic [31:0] h;
      h = ca;
      h = (h * HASH_MUL_A) ^ sa;
      h = (h * HASH_MUL_A) ^ pp;
      h = (h * HASH_MUL_A) ^ tid;
      h = h ^ (h >> 16);
      h = h * HASH_MUL_B;
      h = h ^ (h >> 13);
      return int'(h % SETS);
   endfunction

   function automatic int plru_pick(int set_idx);
      int node = 0, lo = 0, span = tree_width(), half, dir;
      logic [7:0] bits;
      bits = tbl_plru[set_idx];
      while (span > 1) begin
         half = span >> 1;
         dir = (node < 8) ? int'(bits[node]) : 0;
         if (dir != 0 && lo + half >= WAYS) dir = 0;
         if (dir != 0) lo += half;
         node = 2 * node + 1 + dir;
         span = half;
      end
      return lo;
   endfunction

   function automatic void plru_mark(int set_idx, int way);
      int node = 0, lo = 0, span = tree_width(), half, right;
      logic [7:0] bits;
      bits = tbl_plru[set_idx];
      while (span > 1) begin
         half = span >> 1;
         right = (way >= lo + half) ? 1 : 0;
         if (node < 8) bits[node] = (right == 0);
         if (right != 0) lo += half;
         node = 2 * node + 1 + right;
         span = half;
      end
      tbl_plru[set_idx] = bits;
   endfunction

   // header checks, then the table lookup / store / free
   function automatic rsp_type match_latency(req_type r);
      rsp_type res;
      int ihl_bytes, set_idx, base, hit_way;
      logic [31:0] ca, sa, pp;
      res = '0;
      ihl_bytes = int'(r.ip_version_ihl[3:0]) * 4;
      if (r.frame_length < MIN_FRAME || r.ether_type != ETHERTYPE_IPV4) return res;
      if (r.ip_version_ihl[7:4] != IP_VERSION_4 || r.ip_protocol != IP_PROTO_UDP) return res;
      if ((r.frag_field & FRAG_MASK) != 0 || ihl_bytes < 20) return res;
      if (int'(r.frame_length) < 14 + ihl_bytes + 8) return res;
      if (r.udp_sport != cur_svc_port && r.udp_dport != cur_svc_port) return res;
      if (int'(r.frame_length) < 14 + ihl_bytes + 20) return res;
      res.logged = 1'b1;
      res.resp_flag = r.msg_flags[15];
      if (res.resp_flag) begin
         res.rcode = r.msg_flags[3:0];
         ca = r.dst_addr; sa = r.src_addr; pp = {r.udp_dport, r.udp_sport};
      end else begin
         ca = r.src_addr; sa = r.dst_addr; pp = {r.udp_sport, r.udp_dport};
      end
      set_idx = flow_set(ca, sa, pp, {16'h0, r.query_id});
      base = set_idx * WAYS;
      hit_way = WAYS;
      for (int w = 0; w < WAYS; w++) begin
         if (hit_way == WAYS && tbl_valid[base+w] && tbl_client[base+w] == ca &&
             tbl_server[base+w] == sa && tbl_ports[base+w] == pp &&
             tbl_tid[base+w] == r.query_id)
            hit_way = w;
      end
      if (res.resp_flag) begin
         if (hit_way < WAYS) begin
            res.matched = 1'b1;
            res.delta_ns = r.now_ns - tbl_start[base+hit_way];
            tbl_valid[base+hit_way] = 1'b0;
         end
      end else begin
         if (hit_way == WAYS) begin
            for (int w = 0; w < WAYS; w++)
               if (hit_way == WAYS && !tbl_valid[base+w]) hit_way = w;
            if (hit_way == WAYS) hit_way = plru_pick(set_idx);
         end
         tbl_client[base+hit_way] = ca;
         tbl_server[base+hit_way] = sa;
         tbl_ports[base+hit_way] = pp;
         tbl_tid[base+hit_way] = r.query_id;
         tbl_start[base+hit_way] = r.now_ns;
         tbl_valid[base+hit_way] = 1'b1;
         plru_mark(set_idx, hit_way);
      end
      return res;
   endfunction

   // send one request; predict on acceptance; valid stays up when no idle gap follows
   task automatic send_request(req_type r);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(match_latency(r));
      if (!r.msg_flags[15]) begin
         recent_queries.push_back(r);
         if (recent_queries.size() > 64) void'(recent_queries.pop_front());
      end
   endtask

   // drop valid right after the last accepted request
   task automatic stop_requests();
      req_valid <= 1'b0;
   endtask

   // result side: idle gap per result, compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.logged !== want.logged || rsp_data.resp_flag !== want.resp_flag ||
                rsp_data.rcode !== want.rcode || rsp_data.matched !== want.matched ||
                rsp_data.delta_ns !== want.delta_ns) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %p actual %p", want, rsp_data);
            end
         end
         rsp_gap = rsp_idle_enable ? int'($urandom_range(0, 6)) : 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
      end
      rsp_ready <= (rsp_gap == 0);
   end

   // a request that passes every check for the current port
   function automatic req_type good_packet(bit is_resp);
      req_type r;
      r.ether_type = ETHERTYPE_IPV4;
      r.ip_version_ihl = {IP_VERSION_4, 4'(5 + ($urandom_range(0, 3) == 0 ?
                          $urandom_range(0, 10) : 0))};
      r.ip_protocol = IP_PROTO_UDP;
      r.frag_field = $urandom_range(0, 1) ? 16'h4000 : (16'($urandom) & 16'hc000);
      r.src_addr = $urandom;
      r.dst_addr = $urandom;
      r.query_id = 16'($urandom);
      r.msg_flags = {is_resp, 15'($urandom)};
      r.now_ns = {$urandom, $urandom};
      r.frame_length = 16'(14 + 20 + 4 * int'(r.ip_version_ihl[3:0]) + $urandom_range(0, 1500));
      if (is_resp) begin
         r.udp_sport = cur_svc_port; r.udp_dport = 16'($urandom);
      end else begin
         r.udp_sport = 16'($urandom); r.udp_dport = cur_svc_port;
      end
      return r;
   endfunction

   // response to a stored query, possibly with one key field disturbed
   function automatic req_type answer_for(req_type q);
      req_type r;
      r = good_packet(1'b1);
      r.src_addr = q.dst_addr; r.dst_addr = q.src_addr;
      r.udp_sport = q.udp_dport; r.udp_dport = q.udp_sport;
      r.query_id = q.query_id;
      if ($urandom_range(0, 9) == 0) r.query_id ^= 16'(1 << $urandom_range(0, 15));
      return r;
   endfunction

   task automatic write_svc_port(logic [15:0] port);
      // let queue and output register drain before the write
      stop_requests();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= port;
      cur_svc_port = port;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_header_checks();
      req_type base_q, r;
      base_q = good_packet(1'b0);
      send_request(base_q);
      r = base_q; r.ether_type = 16'hffff; send_request(r);
      r = base_q; r.ether_type = 16'h0000; send_request(r);
      r = base_q; r.ip_version_ihl = 8'h65; send_request(r);
      r = base_q; r.ip_version_ihl = 8'h44; send_request(r);
      r = base_q; r.ip_version_ihl = 8'h40; send_request(r);
      r = base_q; r.ip_version_ihl = 8'h4f; r.frame_length = 16'hffff; send_request(r);
      r = base_q; r.ip_protocol = 8'd6; send_request(r);
      r = base_q; r.ip_protocol = 8'hff; send_request(r);
      r = base_q; r.frag_field = 16'h0001; send_request(r);
      r = base_q; r.frag_field = 16'hffff; send_request(r);
      r = base_q; r.frame_length = 16'd33; send_request(r);
      r = base_q; r.frame_length = 16'd0; send_request(r);
      r = base_q; r.ip_version_ihl = 8'h45; r.frame_length = 16'd41; send_request(r);
      r = base_q; r.ip_version_ihl = 8'h45; r.frame_length = 16'd53; send_request(r);
      r = base_q; r.ip_version_ihl = 8'h45; r.frame_length = 16'd54; send_request(r);
      r = base_q; r.udp_sport = 16'd1; r.udp_dport = 16'hffff; send_request(r);
   endtask

   task automatic test_match_and_latency();
      req_type q, a;
      q = good_packet(1'b0); q.now_ns = 64'hffff_ffff_ffff_fff0; send_request(q);
      a = answer_for(q); a.query_id = q.query_id; a.now_ns = 64'h10;
      a.msg_flags = 16'hffff; send_request(a);
      send_request(a);            // entry already freed
      q.now_ns = 64'd100; send_request(q);
      q.now_ns = 64'd0; send_request(q);   // same key, time overwritten
      a.now_ns = 64'd0; a.msg_flags = 16'h8000; send_request(a);
      // send eight more queries with random keys
      for (int i = 0; i < 8; i++) begin
         q = good_packet(1'b0); send_request(q);
      end
   endtask

   task automatic test_random_traffic(int count);
      req_type r;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) r = good_packet(1'b0);
         else if (pick < 85 && recent_queries.size() != 0)
            r = answer_for(recent_queries[$urandom_range(0, recent_queries.size() - 1)]);
         else if (pick < 90) r = good_packet(1'b1);
         else begin
            r = good_packet(1'($urandom_range(0, 1)));
            case ($urandom_range(0, 4))
               0: r.ether_type = 16'($urandom);
               1: r.ip_version_ihl = 8'($urandom);
               2: r.ip_protocol = 8'($urandom);
               3: r.frag_field = 16'($urandom);
               default: r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom});
            endcase
         end
         rsp_idle_enable = (i / 200) % 3 != 2;
         send_request(r);
      end
   endtask

   task automatic test_port_settings();
      write_svc_port(16'hffff);
      test_random_traffic(150);
      write_svc_port(16'h0000);
      test_random_traffic(150);
      write_svc_port(16'd5353);
      test_random_traffic(150);
      write_svc_port(SVC_PORT_RESET);
   endtask

   initial begin
      for (int i = 0; i < NUM_ENTRIES; i++) tbl_valid[i] = 1'b0;
      for (int s = 0; s < SETS; s++) tbl_plru[s] = '0;
      cur_svc_port = SVC_PORT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_header_checks();
      test_match_and_latency();
      test_port_settings();
      test_random_traffic(1000);
      stop_requests();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog: ends the run if ~1500 requests have not finished by then
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/dqlm_pkg.sv
hw/rtl/dqlm_front.sv
hw/rtl/dqlm_fifo.sv
hw/rtl/dqlm_back.sv
hw/rtl/dns_query_latency_matcher_core.sv
dv/tb_top.sv
